// ===== design/bfha_pkg.sv =====
// ----------------------------------------------------------------------------
// bfha_pkg: shared types and constants of the best-fit heap allocator
// Holds the request and response beats, status codes, tag bits and the
// sequencer state type.
// ----------------------------------------------------------------------------
package bfha_pkg;

  localparam int HEAP_BYTES_DEF = 4096;
  localparam int MIN_POS_W      = 13;
  localparam int NEED_W         = 13;

  localparam int TAG_BUSY_BIT = 0;
  localparam int TAG_PREV_BIT = 1;

  localparam logic [0:0] REQ_ALLOC = 1'b0;
  localparam logic [0:0] REQ_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FIT   = 2'd1;
  localparam logic [1:0] ST_BAD_ADDR = 2'd2;
  localparam logic [1:0] ST_DBL_FREE = 2'd3;

  typedef struct packed {
    logic        req_type;
    logic [11:0] req_bytes;
    logic [11:0] payload_offset;
  } req_t;

  typedef struct packed {
    logic [11:0] granted_offset;
    logic [1:0]  status;
  } rsp_t;

  typedef enum logic [4:0] {
    S_INIT0,
    S_INIT1,
    S_INIT2,
    S_IDLE,
    S_AL_WALK,
    S_AL_DECIDE,
    S_AL_W2,
    S_AL_W3,
    S_AL_NX,
    S_FR_WALK,
    S_FR_NEXT,
    S_FR_PFOOT,
    S_FR_PHEAD,
    S_FR_W1,
    S_FR_W2,
    S_FR_W3,
    S_DONE
  } state_t;

endpackage

// ===== design/bfha_tag_ram.sv =====
// ----------------------------------------------------------------------------
// bfha_tag_ram: tag word memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bfha_tag_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/bfha_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfha_ctrl: allocator sequencer
// Walks the block list one tag a cycle through the tag memory, tracks the
// best fit, then splits, merges and patches tags in a few further steps.
// ----------------------------------------------------------------------------
module bfha_ctrl #(
  parameter int HEAP_BYTES = bfha_pkg::HEAP_BYTES_DEF,
  parameter int AW         = 10,
  parameter int TW         = 13
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  bfha_pkg::req_t  req,
  output logic            busy,
  output logic            done,
  output bfha_pkg::rsp_t  rsp,
  output logic            we,
  output logic [AW-1:0]   waddr,
  output logic [TW-1:0]   wdata,
  output logic [AW-1:0]   raddr,
  input  logic [TW-1:0]   rdata
);

  localparam int PW_RAW = $clog2(HEAP_BYTES) + 1;
  localparam int PW     = (PW_RAW > bfha_pkg::MIN_POS_W) ? PW_RAW : bfha_pkg::MIN_POS_W;
  localparam logic [PW-1:0] END_POS = PW'(HEAP_BYTES - 4);
  localparam logic [PW-1:0] FIRST   = PW'(4);
  localparam logic [PW-1:0] FOUR    = PW'(4);
  localparam logic [PW-1:0] EIGHT   = PW'(8);

  bfha_pkg::state_t state, state_next;

  logic [PW-1:0] pos, pos_next;
  logic [PW-1:0] best, best_next;
  logic [PW-1:0] bsz, bsz_next;
  logic          bprev, bprev_next;
  logic          found, found_next;
  logic [PW-1:0] need, need_next;
  logic [PW-1:0] target, target_next;
  logic [TW-1:0] tagr, tagr_next;
  logic [PW-1:0] start_pos, start_pos_next;
  logic [PW-1:0] total, total_next;
  logic          prevbit, prevbit_next;
  bfha_pkg::rsp_t res, res_next;

  logic [PW-1:0] rsize, tsize, npos, raddr_pos, waddr_pos;
  logic          rbusy;
  logic [12:0]   req_ext;

  assign rsize = PW'({rdata[TW-1:3], 3'b000});
  assign tsize = PW'({tagr[TW-1:3], 3'b000});
  assign rbusy = rdata[bfha_pkg::TAG_BUSY_BIT];
  assign npos  = pos + rsize;
  assign req_ext = 13'(req.req_bytes);

  assign raddr = raddr_pos[AW+1:2];
  assign waddr = waddr_pos[AW+1:2];
  assign busy  = (state != bfha_pkg::S_IDLE);
  assign done  = (state == bfha_pkg::S_DONE);
  assign rsp   = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfha_pkg::S_INIT0;
    end else begin
      state <= state_next;
    end
    pos       <= pos_next;
    best      <= best_next;
    bsz       <= bsz_next;
    bprev     <= bprev_next;
    found     <= found_next;
    need      <= need_next;
    target    <= target_next;
    tagr      <= tagr_next;
    start_pos <= start_pos_next;
    total     <= total_next;
    prevbit   <= prevbit_next;
    res       <= res_next;
  end

  always_comb begin
    state_next     = state;
    pos_next       = pos;
    best_next      = best;
    bsz_next       = bsz;
    bprev_next     = bprev;
    found_next     = found;
    need_next      = need;
    target_next    = target;
    tagr_next      = tagr;
    start_pos_next = start_pos;
    total_next     = total;
    prevbit_next   = prevbit;
    res_next       = res;
    we             = 1'b0;
    waddr_pos      = FIRST;
    wdata          = '0;
    raddr_pos      = FIRST;
    case (state)
      bfha_pkg::S_INIT0: begin
        we         = 1'b1;
        waddr_pos  = FIRST;
        wdata      = TW'(HEAP_BYTES - 8) | TW'(1 << bfha_pkg::TAG_PREV_BIT);
        state_next = bfha_pkg::S_INIT1;
      end
      bfha_pkg::S_INIT1: begin
        we         = 1'b1;
        waddr_pos  = END_POS - FOUR;
        wdata      = TW'(HEAP_BYTES - 8);
        state_next = bfha_pkg::S_INIT2;
      end
      bfha_pkg::S_INIT2: begin
        we         = 1'b1;
        waddr_pos  = END_POS;
        wdata      = TW'(1 << bfha_pkg::TAG_BUSY_BIT);
        state_next = bfha_pkg::S_IDLE;
      end
      bfha_pkg::S_IDLE: begin
        if (start) begin
          pos_next   = FIRST;
          found_next = 1'b0;
          raddr_pos  = FIRST;
          res_next.granted_offset = '0;
          if (req.req_type == bfha_pkg::REQ_ALLOC) begin
            need_next  = (req_ext <= 13'd4) ? EIGHT
                         : PW'((req_ext + 13'd11) & ~13'd7);
            state_next = bfha_pkg::S_AL_WALK;
          end else if (req.payload_offset < 12'd8 || req.payload_offset[2:0] != 3'd0) begin
            res_next.status = bfha_pkg::ST_BAD_ADDR;
            state_next      = bfha_pkg::S_DONE;
          end else begin
            target_next = PW'(req.payload_offset) - FOUR;
            state_next  = bfha_pkg::S_FR_WALK;
          end
        end
      end
      bfha_pkg::S_AL_WALK: begin
        if (!rbusy && rsize >= need && (!found || rsize < bsz)) begin
          found_next = 1'b1;
          best_next  = pos;
          bsz_next   = rsize;
          bprev_next = rdata[bfha_pkg::TAG_PREV_BIT];
        end
        if (rsize == '0 || npos >= END_POS) begin
          state_next = bfha_pkg::S_AL_DECIDE;
        end else begin
          pos_next  = npos;
          raddr_pos = npos;
        end
      end
      bfha_pkg::S_AL_DECIDE: begin
        if (!found) begin
          res_next.granted_offset = '0;
          res_next.status         = bfha_pkg::ST_NO_FIT;
          state_next              = bfha_pkg::S_DONE;
        end else if (bsz > need) begin
          we         = 1'b1;
          waddr_pos  = best + need;
          wdata      = TW'(bsz - need) | TW'(1 << bfha_pkg::TAG_PREV_BIT);
          state_next = bfha_pkg::S_AL_W2;
        end else begin
          we         = 1'b1;
          waddr_pos  = best;
          wdata      = TW'(bsz) | TW'({bprev, 1'b1});
          raddr_pos  = best + bsz;
          state_next = bfha_pkg::S_AL_NX;
        end
      end
      bfha_pkg::S_AL_W2: begin
        we         = 1'b1;
        waddr_pos  = best + bsz - FOUR;
        wdata      = TW'(bsz - need);
        state_next = bfha_pkg::S_AL_W3;
      end
      bfha_pkg::S_AL_W3: begin
        we         = 1'b1;
        waddr_pos  = best;
        wdata      = TW'(need) | TW'({bprev, 1'b1});
        res_next.granted_offset = 12'(best + FOUR);
        res_next.status         = bfha_pkg::ST_OK;
        state_next = bfha_pkg::S_DONE;
      end
      bfha_pkg::S_AL_NX: begin
        we         = 1'b1;
        waddr_pos  = best + bsz;
        wdata      = rdata | TW'(1 << bfha_pkg::TAG_PREV_BIT);
        res_next.granted_offset = 12'(best + FOUR);
        res_next.status         = bfha_pkg::ST_OK;
        state_next = bfha_pkg::S_DONE;
      end
      bfha_pkg::S_FR_WALK: begin
        if (pos == target) begin
          if (!rbusy) begin
            res_next.status = bfha_pkg::ST_DBL_FREE;
            state_next      = bfha_pkg::S_DONE;
          end else begin
            tagr_next  = rdata;
            raddr_pos  = target + rsize;
            state_next = bfha_pkg::S_FR_NEXT;
          end
        end else if (rsize == '0 || pos > target || npos >= END_POS) begin
          res_next.status = bfha_pkg::ST_BAD_ADDR;
          state_next      = bfha_pkg::S_DONE;
        end else begin
          pos_next  = npos;
          raddr_pos = npos;
        end
      end
      bfha_pkg::S_FR_NEXT: begin
        total_next = rbusy ? tsize : tsize + rsize;
        if (!tagr[bfha_pkg::TAG_PREV_BIT]) begin
          raddr_pos  = target - FOUR;
          state_next = bfha_pkg::S_FR_PFOOT;
        end else begin
          start_pos_next = target;
          prevbit_next   = 1'b1;
          state_next     = bfha_pkg::S_FR_W1;
        end
      end
      bfha_pkg::S_FR_PFOOT: begin
        start_pos_next = target - rsize;
        total_next     = total + rsize;
        raddr_pos      = target - rsize;
        state_next     = bfha_pkg::S_FR_PHEAD;
      end
      bfha_pkg::S_FR_PHEAD: begin
        prevbit_next = rdata[bfha_pkg::TAG_PREV_BIT];
        state_next   = bfha_pkg::S_FR_W1;
      end
      bfha_pkg::S_FR_W1: begin
        we         = 1'b1;
        waddr_pos  = start_pos;
        wdata      = TW'(total) | TW'({prevbit, 1'b0});
        state_next = bfha_pkg::S_FR_W2;
      end
      bfha_pkg::S_FR_W2: begin
        we         = 1'b1;
        waddr_pos  = start_pos + total - FOUR;
        wdata      = TW'(total);
        raddr_pos  = start_pos + total;
        state_next = bfha_pkg::S_FR_W3;
      end
      bfha_pkg::S_FR_W3: begin
        we         = 1'b1;
        waddr_pos  = start_pos + total;
        wdata      = rdata & ~TW'(1 << bfha_pkg::TAG_PREV_BIT);
        res_next.status = bfha_pkg::ST_OK;
        state_next = bfha_pkg::S_DONE;
      end
      bfha_pkg::S_DONE: begin
        state_next = bfha_pkg::S_IDLE;
      end
      default: begin
        state_next = bfha_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/best_fit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// best_fit_heap_allocator: best-fit allocator over an implicit block list
// Serves allocate and free requests on a byte heap whose block tags live in
// an internal tag memory.
//
//   Channel   Signals             Beat taken when
//   request   start, busy, req    start high and busy low
//   response  done, rsp           done high (one cycle, no back-pressure)
//
// An allocate walks the whole block list at one tag a cycle, set by the single
// tag memory read port; then a no-fit answers, a whole-block grant writes its
// header and the succeeding tag, a split the remainder's header and footer and
// the grant's header. A free walks to its block at one tag a cycle, reads the
// succeeding tag and, if merging backwards, the previous footer and header,
// then writes merged header, footer and succeeding tag; a misaligned offset
// answers in the cycle after the beat. Busy is high during the initial tag
// writes after reset and until the response ends, which cannot be stalled.
// ----------------------------------------------------------------------------
module best_fit_heap_allocator #(
  parameter int HEAP_BYTES = bfha_pkg::HEAP_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  bfha_pkg::req_t req,
  output logic           busy,
  output logic           done,
  output bfha_pkg::rsp_t rsp
);

  localparam int DEPTH = HEAP_BYTES / 4;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = $clog2(HEAP_BYTES) + 1;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [TW-1:0] wdata, rdata;

  bfha_ctrl #(
    .HEAP_BYTES(HEAP_BYTES),
    .AW(AW),
    .TW(TW)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .start(start),
    .req(req),
    .busy(busy),
    .done(done),
    .rsp(rsp),
    .we(we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  bfha_tag_ram #(
    .DEPTH(DEPTH),
    .AW(AW),
    .DW(TW)
  ) u_ram (
    .clk(clk),
    .we(we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

endmodule

// ===== tb/best_fit_heap_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_heap_allocator_tb: self-checking bench for the best-fit allocator
// Keeps its own image of the block tags and, for every request beat that the
// block takes, computes the granted offset and status the heap must yield.
// Responses are compared in order against that queue. Directed allocate and
// free sequences come first, then random workloads that keep a list of live
// blocks so that most frees are well formed, mixed with bad and double frees.
// ----------------------------------------------------------------------------
module best_fit_heap_allocator_tb;

  localparam int HEAP = 4096;
  localparam int WORDS = HEAP / 4;
  localparam int END_AT = HEAP - 4;
  localparam int LIMIT = 4000000;

  logic clk;
  logic rst;
  logic start;
  bfha_pkg::req_t req;
  logic busy;
  logic done;
  bfha_pkg::rsp_t rsp;

  int tags [WORDS];
  bfha_pkg::rsp_t pending_rsp [$];
  int live_blocks [$];
  int errors;
  int cycles;

  best_fit_heap_allocator #(.HEAP_BYTES(HEAP)) uut (
    .clk(clk), .rst(rst), .start(start), .req(req),
    .busy(busy), .done(done), .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int tag_rd(int pos);
    return (pos >> 2) < WORDS ? tags[pos >> 2] : 0;
  endfunction

  function automatic void tag_wr(int pos, int v);
    if ((pos >> 2) < WORDS) tags[pos >> 2] = v;
  endfunction

  function automatic void heap_reset();
    foreach (tags[i]) tags[i] = 0;
    tag_wr(4, (HEAP - 8) | 2);
    tag_wr(END_AT - 4, HEAP - 8);
    tag_wr(END_AT, 1);
  endfunction

  function automatic bfha_pkg::rsp_t heap_alloc(int bytes);
    bfha_pkg::rsp_t r;
    int need, pos, best, bsz, t, s, pb, rest;
    bit found;
    need = bytes <= 4 ? 8 : ((bytes + 11) / 8) * 8;
    pos = 4;
    found = 0;
    best = 0;
    bsz = 0;
    while (pos < END_AT) begin
      t = tag_rd(pos);
      s = t & ~7;
      if (s == 0) break;
      if (!(t & 1) && s >= need && (!found || s < bsz)) begin
        found = 1;
        best = pos;
        bsz = s;
      end
      pos += s;
    end
    if (!found) begin
      r.granted_offset = '0;
      r.status = bfha_pkg::ST_NO_FIT;
      return r;
    end
    pb = tag_rd(best) & 2;
    if (bsz - need >= 8) begin
      rest = bsz - need;
      tag_wr(best + need, rest | 2);
      tag_wr(best + bsz - 4, rest);
      tag_wr(best, need | pb | 1);
    end else begin
      tag_wr(best, bsz | pb | 1);
      tag_wr(best + bsz, tag_rd(best + bsz) | 2);
    end
    r.granted_offset = 12'(best + 4);
    r.status = bfha_pkg::ST_OK;
    return r;
  endfunction

  function automatic bfha_pkg::rsp_t heap_free(int off);
    bfha_pkg::rsp_t r;
    int target, pos, s, t, sz, first, total, pb, ps;
    bit hit;
    r.granted_offset = '0;
    r.status = bfha_pkg::ST_BAD_ADDR;
    if (off < 8 || (off & 7) != 0) return r;
    target = off - 4;
    pos = 4;
    hit = 0;
    while (pos < END_AT) begin
      s = tag_rd(pos) & ~7;
      if (pos == target) begin
        hit = 1;
        break;
      end
      if (s == 0 || pos > target) break;
      pos += s;
    end
    if (!hit) return r;
    t = tag_rd(target);
    if (!(t & 1)) begin
      r.status = bfha_pkg::ST_DBL_FREE;
      return r;
    end
    sz = t & ~7;
    first = target;
    total = sz;
    pb = t & 2;
    if (!(tag_rd(target + sz) & 1)) total += tag_rd(target + sz) & ~7;
    if (!pb) begin
      ps = tag_rd(target - 4) & ~7;
      first = target - ps;
      pb = tag_rd(first) & 2;
      total += ps;
    end
    tag_wr(first, total | pb);
    tag_wr(first + total - 4, total);
    tag_wr(first + total, tag_rd(first + total) & ~2);
    r.status = bfha_pkg::ST_OK;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  task automatic send_request(logic kind, int bytes, int off);
    bfha_pkg::rsp_t r;
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
    repeat (gap) @(posedge clk);
    start <= 1'b1;
    req <= '{req_type: kind, req_bytes: 12'(bytes), payload_offset: 12'(off)};
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
    r = (kind == bfha_pkg::REQ_ALLOC) ? heap_alloc(bytes & 12'hFFF)
                                      : heap_free(off & 12'hFFF);
    pending_rsp.push_back(r);
    if (kind == bfha_pkg::REQ_ALLOC && r.status == bfha_pkg::ST_OK)
      live_blocks.push_back(r.granted_offset);
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected beat", rsp.status, -1);
      end else begin
        if (rsp.granted_offset !== pending_rsp[0].granted_offset)
          report_mismatch("granted_offset", rsp.granted_offset,
                          pending_rsp[0].granted_offset);
        if (rsp.status !== pending_rsp[0].status)
          report_mismatch("status", rsp.status, pending_rsp[0].status);
        void'(pending_rsp.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("best_fit_heap_allocator_tb: FAIL");
      $finish;
    end
  end

  task automatic free_live(int idx);
    int off;
    off = live_blocks[idx];
    live_blocks.delete(idx);
    send_request(bfha_pkg::REQ_FREE, $urandom, off);
  endtask

  task automatic test_directed();
    send_request(bfha_pkg::REQ_ALLOC, 0, 0);
    send_request(bfha_pkg::REQ_ALLOC, 4, 4095);
    send_request(bfha_pkg::REQ_ALLOC, 5, 0);
    send_request(bfha_pkg::REQ_ALLOC, 4095, 0);
    send_request(bfha_pkg::REQ_FREE, 0, 0);
    send_request(bfha_pkg::REQ_FREE, 0, 12);
    send_request(bfha_pkg::REQ_FREE, 0, 4088);
    send_request(bfha_pkg::REQ_FREE, 4095, 4095);
    send_request(bfha_pkg::REQ_FREE, 0, 16);
    send_request(bfha_pkg::REQ_FREE, 0, 16);
    send_request(bfha_pkg::REQ_FREE, 0, 8);
    send_request(bfha_pkg::REQ_FREE, 0, 24);
    live_blocks.delete();
    send_request(bfha_pkg::REQ_ALLOC, 4084, 0);
    send_request(bfha_pkg::REQ_ALLOC, 4000, 0);
    send_request(bfha_pkg::REQ_ALLOC, 4, 0);
    send_request(bfha_pkg::REQ_FREE, 0, 8);
    live_blocks.delete();
    send_request(bfha_pkg::REQ_ALLOC, 4080, 0);
    send_request(bfha_pkg::REQ_FREE, 0, 8);
    send_request(bfha_pkg::REQ_ALLOC, 4076, 0);
    send_request(bfha_pkg::REQ_FREE, 0, 8);
    live_blocks.delete();
  endtask

  task automatic test_random();
    int sel;
    repeat (1030) begin
      sel = $urandom_range(0, 99);
      if (sel < 48) begin
        send_request(bfha_pkg::REQ_ALLOC,
                     $urandom_range(0, 9) == 0 ? $urandom_range(0, 4095)
                                               : $urandom_range(0, 200),
                     $urandom);
      end else if (sel < 88 && live_blocks.size() > 0) begin
        free_live($urandom_range(0, live_blocks.size() - 1));
      end else if (sel < 94) begin
        send_request(bfha_pkg::REQ_FREE, $urandom, $urandom_range(0, 4095));
      end else begin
        send_request(bfha_pkg::REQ_FREE, $urandom, $urandom_range(1, 511) * 8);
      end
    end
    while (live_blocks.size() > 0) free_live(0);
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    heap_reset();
    rst <= 1'b1;
    start <= 1'b0;
    req <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random();
    while (pending_rsp.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("best_fit_heap_allocator_tb: PASS");
    end else begin
      $display("best_fit_heap_allocator_tb: FAIL");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
design/bfha_pkg.sv
design/bfha_tag_ram.sv
design/bfha_ctrl.sv
design/best_fit_heap_allocator.sv
tb/best_fit_heap_allocator_tb.sv
